// File: rtl/gradient_orientation_energy_profile_top_assert.svh
// Assertion macros for the gradient orientation energy profile block.
`ifndef GRADIENT_ORIENTATION_ENERGY_PROFILE_TOP_ASSERT_SVH
`define GRADIENT_ORIENTATION_ENERGY_PROFILE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GOEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GOEP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/goep_pkg.sv
// Types, constants and helper functions shared by the gradient energy block.
`default_nettype none
package goep_pkg;

	localparam int CoordW = 12;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [1:0]        bank_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ALPHA_WEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		EK_UPPER,
		EK_LEFT,
		EK_LAST
	} emit_kind_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_WR,
		BS_RA,
		BS_RB,
		BS_RC,
		BS_RD,
		BS_DIF,
		BS_SQ,
		BS_MUL1,
		BS_MUL2,
		BS_OUT
	} back_state_t;

	// Effective frame geometry and weights after clamping.
	typedef struct packed {
		coord_t     col_last;
		coord_t     row_last;
		logic [8:0] alpha;
		logic [8:0] alpha_inv;
	} cfg_t;

	// One accepted pixel together with its classification.
	typedef struct packed {
		logic [7:0] pixel;
		coord_t     row;
		coord_t     col;
		bank_t      bank;
		logic       last_col;
		logic       has_upper;
		logic       has_left;
		logic       has_last;
	} item_t;

	typedef struct packed {
		logic at_origin;
	} front_stat_t;

	typedef struct packed {
		logic idle;
		logic load;
	} back_stat_t;

	function automatic bank_t bank_next(input bank_t b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

	function automatic bank_t bank_prev(input bank_t b);
		return (b == 2'd0) ? 2'd2 : b - 2'd1;
	endfunction

endpackage
`default_nettype wire

// File: rtl/gradient_orientation_energy_profile_top.sv
// Top level of the gradient orientation energy profile block.
//
//  Channel   Handshake             Payload
//  input     push / full           pixel_value
//  result    pop / empty           out_row, out_col, hor_energy, ver_energy,
//                                  row_hor_total, row_ver_total, row_end, last_of_run
//  config    wr_en                 wr_index, wr_data
//
// A pixel of row 0 is only written to the line store; any other pixel also reports
// one pixel (up to three in the last row), each by four reads of the single line
// store read port and then the difference, square, multiply and output states.
// A two-entry queue lets the front accept pixels while the back end works, and
// the result register lets the back end run up to its output state while a result
// waits for pop. Reset clears control state and row sums, never the line store.
`default_nettype none
`include "gradient_orientation_energy_profile_top_assert.svh"
module gradient_orientation_energy_profile_top
	import goep_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  pixel_value,
	output logic             empty,
	input  wire logic        pop,
	output logic [9:0]       out_row,
	output logic [9:0]       out_col,
	output logic [25:0]      hor_energy,
	output logic [25:0]      ver_energy,
	output logic [35:0]      row_hor_total,
	output logic [35:0]      row_ver_total,
	output logic             row_end,
	output logic             last_of_run,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [10:0] wr_data
);

	logic [10:0] width_q, height_q;
	logic [8:0]  alpha_q;
	logic [12:0] w_eff, h_eff;
	logic [8:0]  a_eff;
	cfg_t        cfg;
	logic        restart;
	logic        accept;
	item_t       f_item, q_item;
	logic        q_valid, q_pop;
	front_stat_t f_stat;
	back_stat_t  b_stat;

	assign accept  = push && !full;
	assign restart = wr_en && ((wr_index == REG_IMAGE_WIDTH) || (wr_index == REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 11'd480;
			alpha_q  <= 9'd230;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				REG_ALPHA_WEIGHT: alpha_q  <= wr_data[8:0];
				default: ;
			endcase
		end
	end

	// Out of range sizes are clamped; alpha saturates at one.
	always_comb begin
		w_eff = {2'b00, width_q};
		if (w_eff < 13'd2) w_eff = 13'd2;
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = {2'b00, height_q};
		if (h_eff < 13'd2) h_eff = 13'd2;
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
		a_eff         = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
		cfg.col_last  = coord_t'(w_eff - 13'd1);
		cfg.row_last  = coord_t'(h_eff - 13'd1);
		cfg.alpha     = a_eff;
		cfg.alpha_inv = 9'd256 - a_eff;
	end

	goep_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.accept  (accept),
		.pixel   (pixel_value),
		.item    (f_item),
		.stat    (f_stat)
	);

	goep_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_item (f_item),
		.full    (full),
		.rd      (q_pop),
		.valid   (q_valid),
		.rd_item (q_item)
	);

	goep_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.out_row       (out_row),
		.out_col       (out_col),
		.hor_energy    (hor_energy),
		.ver_energy    (ver_energy),
		.row_hor_total (row_hor_total),
		.row_ver_total (row_ver_total),
		.row_end       (row_end),
		.last_of_run   (last_of_run),
		.stat          (b_stat)
	);

	`GOEP_ASSERT_NXT(a_back_drains, q_valid && b_stat.idle, !b_stat.idle, "back end ignored a queued pixel")
	`GOEP_ASSERT_IMP(a_slot_free, b_stat.load, empty || pop, "result register overwritten before transfer")
	`GOEP_ASSERT_NXT(a_restart, restart, f_stat.at_origin, "frame restart did not clear position")

endmodule
`default_nettype wire

// File: rtl/goep_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module goep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 3072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/goep_front.sv
// Front end: accepts pixels, tracks the raster position and classifies each pixel.
`default_nettype none
module goep_front
	import goep_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  restart,
	input  wire logic  accept,
	input  wire logic [7:0] pixel,
	output item_t       item,
	output front_stat_t stat
);

	coord_t row_q;
	coord_t col_q;
	bank_t  bank_q;
	logic   last_col;
	logic   last_row;

	assign last_col = (col_q == cfg.col_last);
	assign last_row = (row_q == cfg.row_last);

	always_comb begin
		item.pixel     = pixel;
		item.row       = row_q;
		item.col       = col_q;
		item.bank      = bank_q;
		item.last_col  = last_col;
		item.has_upper = (row_q != '0);
		item.has_left  = (row_q != '0) && last_row && (col_q != '0);
		item.has_last  = (row_q != '0) && last_row && last_col;
	end

	assign stat.at_origin = (row_q == '0) && (col_q == '0) && (bank_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 2'd0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 2'd0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					bank_q <= 2'd0;
				end else begin
					row_q  <= row_q + coord_t'(1);
					bank_q <= bank_next(bank_q);
				end
			end else begin
				col_q <= col_q + coord_t'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/goep_queue.sv
// Two-entry queue of classified pixels between the front and back ends.
`default_nettype none
module goep_queue
	import goep_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire item_t wr_item,
	output logic       full,
	input  wire logic  rd,
	output logic       valid,
	output item_t      rd_item
);

	item_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign rd_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/goep_back.sv
// Back end: stores pixels in the line store and works out each reported pixel's energies.
`default_nettype none
module goep_back
	import goep_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_pop,
	input  wire logic  pop,
	output logic       empty,
	output logic [9:0]  out_row,
	output logic [9:0]  out_col,
	output logic [25:0] hor_energy,
	output logic [25:0] ver_energy,
	output logic [35:0] row_hor_total,
	output logic [35:0] row_ver_total,
	output logic        row_end,
	output logic        last_of_run,
	output back_stat_t  stat
);

	localparam int Depth = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(Depth);

	back_state_t state_q, state_d;
	item_t       item_q;
	emit_kind_t  kind_q;
	logic [7:0]  opa_q, opb_q, opc_q, opd_q;
	logic [17:0] sx_q, sy_q;
	logic [26:0] hp_q, hn_q, vp_q, vn_q;
	logic [36:0] sum_h_q [2];
	logic [36:0] sum_v_q [2];
	logic        ovalid_q;

	logic          ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;
	logic          load;

	coord_t     em_row, em_col;
	logic       em_end, inner_dy;
	bank_t      xbank, ybank_b;
	coord_t     xa_col, xb_col;
	logic       dx_dbl;
	logic       more;
	emit_kind_t nxt_kind;

	logic signed [9:0]  dxv, dyv;
	logic signed [19:0] dx_sq, dy_sq;
	logic [25:0] he, ve;
	logic [36:0] new_h, new_v;
	logic        s;

	function automatic logic [AW-1:0] addr_of(input bank_t b, input coord_t c);
		logic [AW-1:0] base;
		case (b)
			2'd1:    base = AW'(MAX_WIDTH);
			2'd2:    base = AW'(2 * MAX_WIDTH);
			default: base = '0;
		endcase
		return base + AW'(c);
	endfunction

	goep_ram #(.WIDTH(8), .DEPTH(Depth)) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (item_q.pixel),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Position and neighbour addresses of the pixel now being reported, and whether another follows.
	always_comb begin
		em_row   = (kind_q == EK_UPPER) ? item_q.row - coord_t'(1) : item_q.row;
		em_col   = (kind_q == EK_LEFT) ? item_q.col - coord_t'(1) : item_q.col;
		case (kind_q)
			EK_UPPER: em_end = item_q.last_col;
			EK_LAST:  em_end = 1'b1;
			default:  em_end = 1'b0;
		endcase
		xbank    = (kind_q == EK_UPPER) ? bank_prev(item_q.bank) : item_q.bank;
		inner_dy = (kind_q == EK_UPPER) && (item_q.row != coord_t'(1));
		ybank_b  = inner_dy ? bank_next(item_q.bank) : bank_prev(item_q.bank);
		if (em_col == '0) begin
			xa_col = coord_t'(1);
			xb_col = '0;
			dx_dbl = 1'b1;
		end else if (em_end) begin
			xa_col = em_col;
			xb_col = em_col - coord_t'(1);
			dx_dbl = 1'b1;
		end else begin
			xa_col = em_col + coord_t'(1);
			xb_col = em_col - coord_t'(1);
			dx_dbl = 1'b0;
		end
		case (kind_q)
			EK_UPPER: begin
				more     = item_q.has_left || item_q.has_last;
				nxt_kind = item_q.has_left ? EK_LEFT : EK_LAST;
			end
			EK_LEFT: begin
				more     = item_q.has_last;
				nxt_kind = EK_LAST;
			end
			default: begin
				more     = 1'b0;
				nxt_kind = EK_LAST;
			end
		endcase
	end

	// Gradients are kept doubled so that border differences stay integer.
	always_comb begin
		dxv   = $signed({2'b00, opa_q}) - $signed({2'b00, opb_q});
		dyv   = $signed({2'b00, opc_q}) - $signed({2'b00, opd_q});
		if (dx_dbl) begin
			dxv = dxv <<< 1;
		end
		if (!inner_dy) begin
			dyv = dyv <<< 1;
		end
		dx_sq = dxv * dxv;
		dy_sq = dyv * dyv;
		he    = (hp_q > hn_q) ? 26'(hp_q - hn_q) : '0;
		ve    = (vp_q > vn_q) ? 26'(vp_q - vn_q) : '0;
		s     = em_row[0];
		new_h = ((em_col == '0) ? 37'd0 : sum_h_q[s]) + 37'(he);
		new_v = ((em_col == '0) ? 37'd0 : sum_v_q[s]) + 37'(ve);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: if (q_valid) state_d = BS_WR;
			BS_WR:   state_d = item_q.has_upper ? BS_RA : BS_IDLE;
			BS_RA:   state_d = BS_RB;
			BS_RB:   state_d = BS_RC;
			BS_RC:   state_d = BS_RD;
			BS_RD:   state_d = BS_DIF;
			BS_DIF:  state_d = BS_SQ;
			BS_SQ:   state_d = BS_MUL1;
			BS_MUL1: state_d = BS_MUL2;
			BS_MUL2: state_d = BS_OUT;
			BS_OUT: begin
				if (!ovalid_q || pop) begin
					state_d = more ? BS_RA : BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = (state_q == BS_IDLE) && q_valid;
		ram_we = (state_q == BS_WR);
		waddr  = addr_of(item_q.bank, item_q.col);
		load   = (state_q == BS_OUT) && (!ovalid_q || pop);
		case (state_q)
			BS_RA:   raddr = addr_of(xbank, xa_col);
			BS_RB:   raddr = addr_of(xbank, xb_col);
			BS_RC:   raddr = addr_of(item_q.bank, em_col);
			BS_RD:   raddr = addr_of(ybank_b, em_col);
			default: raddr = addr_of(xbank, xa_col);
		endcase
	end

	assign stat.idle = (state_q == BS_IDLE);
	assign stat.load = load;
	assign empty     = !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_IDLE;
			ovalid_q <= 1'b0;
			kind_q   <= EK_UPPER;
			sum_h_q  <= '{default: '0};
			sum_v_q  <= '{default: '0};
		end else begin
			state_q <= state_d;
			if (load) begin
				ovalid_q   <= 1'b1;
				sum_h_q[s] <= new_h;
				sum_v_q[s] <= new_v;
				if (more) begin
					kind_q <= nxt_kind;
				end
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == BS_WR) begin
				kind_q <= EK_UPPER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		case (state_q)
			BS_RB:   opa_q <= rdata;
			BS_RC:   opb_q <= rdata;
			BS_RD:   opc_q <= rdata;
			BS_DIF:  opd_q <= rdata;
			BS_SQ: begin
				sx_q <= 18'(dx_sq);
				sy_q <= 18'(dy_sq);
			end
			BS_MUL1: begin
				hp_q <= sy_q * cfg.alpha_inv;
				hn_q <= sx_q * cfg.alpha;
			end
			BS_MUL2: begin
				vp_q <= sx_q * cfg.alpha_inv;
				vn_q <= sy_q * cfg.alpha;
			end
			default: ;
		endcase
		if (load) begin
			out_row       <= 10'(em_row);
			out_col       <= 10'(em_col);
			hor_energy    <= he;
			ver_energy    <= ve;
			row_hor_total <= em_end ? 36'(new_h) : '0;
			row_ver_total <= em_end ? 36'(new_v) : '0;
			row_end       <= em_end;
			last_of_run   <= !more;
		end
	end

endmodule
`default_nettype wire
